// ===== src/txc_pkg.sv =====
`timescale 1ns / 1ps

package txc_pkg;

   // screen geometry defaults
   localparam int COLS_DEFAULT = 80;
   localparam int ROWS_DEFAULT = 25;

   localparam logic [7:0] NEWLINE_CODE       = 8'd10;
   localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

   // item kinds
   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] character;
      logic       use_cursor;
      logic [6:0] col;
      logic [4:0] row;
      logic [7:0] attribute;
   } req_item_type;

   typedef struct packed {
      logic [11:0] cursor_byte_pos;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
   } rsp_item_type;

   typedef logic [7:0] csr_data_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic commit;
      logic load_rsp;
      logic clear_step;
      logic scroll_step;
      logic sweep_rst;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_read;
      logic wrap;
      logic clear_last;
      logic scroll_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== src/txc_chan_if.sv =====
`timescale 1ns / 1ps

interface txc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/txc_datapath.sv =====
`timescale 1ns / 1ps

module txc_datapath #(
   parameter int COLS = txc_pkg::COLS_DEFAULT,
   parameter int ROWS = txc_pkg::ROWS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  txc_pkg::ctrl_cmd_type cmd,
   output txc_pkg::dp_status_type status,
   input  txc_pkg::req_item_type req_item,
   input  logic                  csr_valid,
   input  txc_pkg::csr_data_type csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output txc_pkg::rsp_item_type rsp_item
);

   localparam int CELLS = COLS * ROWS;
   localparam int COPY  = COLS * (ROWS - 1);
   localparam int CW    = $clog2(CELLS);
   localparam int SW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int CLW   = $clog2(COLS);

   logic [15:0]    cells_ff [CELLS];
   logic [15:0]    rdata_ff;
   logic [7:0]     default_attr_ff;
   logic [RW-1:0]  cursor_row_ff, cursor_row_in;
   logic [CLW-1:0] cursor_col_ff, cursor_col_in;
   logic           kind_ff;
   logic [7:0]     char_ff;
   logic [7:0]     attr_ff;
   logic [RW-1:0]  tgt_row_ff;
   logic [CLW-1:0] tgt_col_ff;
   logic [CW-1:0]  addr_ff;
   logic [SW-1:0]  sweep_ff;
   logic           rsp_valid_ff;
   txc_pkg::rsp_item_type rsp_item_ff;

   logic [RW-1:0]  sat_row, sel_row, row_plus;
   logic [CLW-1:0] sat_col, sel_col;
   logic [CW-1:0]  req_addr;
   logic           is_newline, row_last, col_last, advance_row;
   logic [SW-1:0]  sweep_m1;
   logic           mem_we, mem_re;
   logic [CW-1:0]  mem_waddr, mem_raddr;
   logic [15:0]    mem_wdata;
   logic [10:0]    cur_cell;

   // target cell of an incoming item, saturated into the screen
   always_comb begin
      sat_row = (32'(req_item.row) > 32'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(req_item.row);
      sat_col = (32'(req_item.col) > 32'(COLS - 1)) ? CLW'(COLS - 1) : CLW'(req_item.col);
      if (req_item.kind == txc_pkg::KIND_PUT && req_item.use_cursor) begin
         sel_row = cursor_row_ff;
         sel_col = cursor_col_ff;
      end else begin
         sel_row = sat_row;
         sel_col = sat_col;
      end
      req_addr = CW'(32'(sel_row) * 32'(COLS) + 32'(sel_col));
   end

   // cursor advance
   always_comb begin
      is_newline  = (char_ff == txc_pkg::NEWLINE_CODE);
      row_last    = (tgt_row_ff == RW'(ROWS - 1));
      col_last    = (tgt_col_ff == CLW'(COLS - 1));
      advance_row = is_newline || col_last;
      row_plus    = tgt_row_ff + RW'(1);
      if (cmd.commit) begin
         cursor_col_in = advance_row ? '0 : tgt_col_ff + CLW'(1);
         cursor_row_in = (advance_row && !row_last) ? row_plus : tgt_row_ff;
      end else begin
         cursor_col_in = cursor_col_ff;
         cursor_row_in = cursor_row_ff;
      end
      cur_cell = 11'(32'(cursor_row_in) * 32'(COLS) + 32'(cursor_col_in));
   end

   always_comb begin
      status.is_read     = (kind_ff == txc_pkg::KIND_READ);
      status.wrap        = row_last && advance_row;
      status.clear_last  = (sweep_ff == SW'(CELLS - 1));
      status.scroll_last = (sweep_ff == SW'(CELLS));
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // memory port selection
   always_comb begin
      sweep_m1  = sweep_ff - SW'(1);
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = {attr_ff, char_ff};
      mem_re    = 1'b0;
      mem_raddr = req_addr;
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff[CW-1:0];
         mem_wdata = '0;
      end else if (cmd.scroll_step) begin
         mem_we    = (sweep_ff != '0);
         mem_waddr = sweep_m1[CW-1:0];
         mem_wdata = (32'(sweep_ff) <= 32'(COPY)) ? rdata_ff : '0;
         mem_re    = (32'(sweep_ff) < 32'(COPY));
         mem_raddr = CW'(32'(sweep_ff) + 32'(COLS));
      end else begin
         mem_we = cmd.commit && !is_newline;
         mem_re = cmd.accept;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= cells_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= txc_pkg::DEFAULT_ATTR_RESET;
         cursor_row_ff   <= '0;
         cursor_col_ff   <= '0;
         sweep_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            default_attr_ff <= csr_data;
         end
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         if (cmd.sweep_rst) begin
            sweep_ff <= '0;
         end else if (cmd.clear_step || cmd.scroll_step) begin
            sweep_ff <= sweep_ff + SW'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= req_item.kind;
         char_ff    <= req_item.character;
         attr_ff    <= (req_item.attribute == '0) ? default_attr_ff : req_item.attribute;
         tgt_row_ff <= sel_row;
         tgt_col_ff <= sel_col;
         addr_ff    <= req_addr;
      end
      if (cmd.load_rsp) begin
         rsp_item_ff.cursor_byte_pos <= {cur_cell, 1'b0};
         rsp_item_ff.read_char       <= status.is_read ? rdata_ff[7:0] : '0;
         rsp_item_ff.read_attr       <= status.is_read ? rdata_ff[15:8] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== src/txc_ctrl.sv =====
`timescale 1ns / 1ps

module txc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  txc_pkg::dp_status_type status,
   output txc_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               cmd.sweep_rst = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_read) begin
               if (status.rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.commit = 1'b1;
               if (status.wrap) begin
                  cmd.sweep_rst = 1'b1;
                  state_in      = ST_SCROLL;
               end else if (status.rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.scroll_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// ===== src/text_console_char_writer_unit.sv =====
`timescale 1ns / 1ps

// channel  dir  payload                                          handshake
// req_chan in   kind, character, use_cursor, col, row, attribute valid/ready
// rsp_chan out  cursor_byte_pos, read_char, read_attr            valid/ready
// csr_chan in   default_attr (8 bits)                            valid/ready, always ready
//
// a read or an ordinary put: accept, then a commit (puts only) and a load of the result register
// a put that runs past the last cell adds a scroll sweep through the single-write, single-read
// screen memory, then a step to load the result
// after reset a clearing pass zeroes the screen; no item is taken
// until it ends, default_attr writes are taken throughout
// a stalled result waits in its register; the block holds the next step until it drains

module text_console_char_writer_unit #(
   parameter int COLS = txc_pkg::COLS_DEFAULT,
   parameter int ROWS = txc_pkg::ROWS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   txc_chan_if.sink   req_chan,
   txc_chan_if.source rsp_chan,
   txc_chan_if.sink   csr_chan
);

   txc_pkg::ctrl_cmd_type  cmd;
   txc_pkg::dp_status_type status;
   logic                   req_ready;
   logic                   rsp_valid;
   txc_pkg::rsp_item_type  rsp_item;

   // sequencer: clear pass, accept, commit, scroll sweep, result hand-off
   txc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // screen memory, cursor, item registers and result register
   txc_datapath #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_chan.payload),
      .csr_valid (csr_chan.valid),
      .csr_data  (csr_chan.payload),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign req_chan.ready   = req_ready;
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_item;

   // one item in flight: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("item accepted while previous item in flight");

   // a result is only loaded into a free output register
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result overwrote a pending item");

   // cursor offset is twice a cell index
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.cursor_byte_pos[0] == 1'b0))
      else $error("odd cursor offset");

endmodule
